/* src/lkv_pkg.sv */
// Shared constants, types and state encoding for the LRU key/value cache.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int WORD_W  = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [WORD_W-1:0] MISS_VALUE = '1;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic search;
        logic commit;
    } t_ctrl_cmd;

endpackage

/* src/lkv_ctrl.sv */
// Controller state machine: sequences accept, search and commit of one request.
`timescale 1ns / 1ps

module lkv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output lkv_pkg::t_ctrl_cmd o_cmd
);

    lkv_pkg::t_state r_state;
    lkv_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lkv_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lkv_pkg::ST_SEARCH;
                end
            end
            lkv_pkg::ST_SEARCH: begin
                n_state = lkv_pkg::ST_COMMIT;
            end
            lkv_pkg::ST_COMMIT: begin
                n_state = lkv_pkg::ST_IDLE;
            end
            default: begin
                n_state = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy         = 1'b1;
        o_cmd.load   = 1'b0;
        o_cmd.search = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            lkv_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            lkv_pkg::ST_SEARCH: begin
                o_cmd.search = 1'b1;
            end
            lkv_pkg::ST_COMMIT: begin
                o_cmd.commit = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* src/lkv_dp.sv */
// Datapath: entry store, parallel key match, recency ranks and result registers.
`timescale 1ns / 1ps

module lkv_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkv_pkg::t_ctrl_cmd                i_cmd_bus,
    input  logic                              i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  logic                              i_cmd,
    input  logic signed [lkv_pkg::WORD_W-1:0] i_lookup_key,
    input  logic signed [lkv_pkg::WORD_W-1:0] i_write_value,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic signed [lkv_pkg::WORD_W-1:0] o_read_value,
    output logic                              o_evicted,
    output logic signed [lkv_pkg::WORD_W-1:0] o_evicted_key
);

    logic [lkv_pkg::CAP_W-1:0]  r_capacity;
    logic                       r_cmd;
    logic [lkv_pkg::WORD_W-1:0] r_key;
    logic [lkv_pkg::WORD_W-1:0] r_val;

    logic [lkv_pkg::WORD_W-1:0] r_keys   [lkv_pkg::ENTRIES];
    logic [lkv_pkg::WORD_W-1:0] r_values [lkv_pkg::ENTRIES];
    logic [lkv_pkg::ENTRIES-1:0] r_valid;
    logic [lkv_pkg::IDX_W-1:0]  r_rank   [lkv_pkg::ENTRIES];
    logic [lkv_pkg::CNT_W-1:0]  r_count;

    logic                       r_hit;
    logic                       r_evict;
    logic [lkv_pkg::IDX_W-1:0]  r_sel;

    logic                       r_out_valid;
    logic                       r_out_hit;
    logic [lkv_pkg::WORD_W-1:0] r_out_read;
    logic                       r_out_evicted;
    logic [lkv_pkg::WORD_W-1:0] r_out_evk;

    logic [lkv_pkg::CNT_W-1:0]  eff_cap;
    logic                       full;
    logic                       any_match;
    logic [lkv_pkg::IDX_W-1:0]  match_idx;
    logic [lkv_pkg::IDX_W-1:0]  oldest_idx;
    logic [lkv_pkg::IDX_W-1:0]  free_idx;
    logic [lkv_pkg::IDX_W-1:0]  oldest_rank;
    logic [lkv_pkg::IDX_W-1:0]  sel_rank;
    logic [lkv_pkg::ENTRIES-1:0] age_inc;

    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = lkv_pkg::CNT_W'(1);
        end else if (int'(r_capacity) > lkv_pkg::ENTRIES) begin
            eff_cap = lkv_pkg::CNT_W'(lkv_pkg::ENTRIES);
        end else begin
            eff_cap = lkv_pkg::CNT_W'(r_capacity);
        end
    end

    assign full        = (r_count >= eff_cap);
    assign oldest_rank = lkv_pkg::IDX_W'(r_count - lkv_pkg::CNT_W'(1));

    always_comb begin
        any_match  = 1'b0;
        match_idx  = '0;
        oldest_idx = '0;
        free_idx   = '0;
        for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_keys[i] == r_key)) begin
                any_match = 1'b1;
                match_idx = lkv_pkg::IDX_W'(i);
            end
            if (r_valid[i] && (r_rank[i] == oldest_rank)) begin
                oldest_idx = lkv_pkg::IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = lkv_pkg::IDX_W'(i);
            end
        end
    end

    assign sel_rank = r_rank[r_sel];

    always_comb begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            age_inc[i] = r_valid[i] && (lkv_pkg::IDX_W'(i) != r_sel)
                         && (!r_hit || (r_rank[i] < sel_rank));
        end
    end

    // control state: valid marks, ranks, occupancy, capacity, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= lkv_pkg::CAP_RESET;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            r_out_valid <= i_cmd_bus.commit;
            if (i_cmd_bus.commit && (r_hit || (r_cmd == lkv_pkg::CMD_PUT))) begin
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (age_inc[i]) begin
                        r_rank[i] <= r_rank[i] + lkv_pkg::IDX_W'(1);
                    end
                end
                r_rank[r_sel] <= '0;
                if (!r_hit) begin
                    r_valid[r_sel] <= 1'b1;
                    if (!r_evict) begin
                        r_count <= r_count + lkv_pkg::CNT_W'(1);
                    end
                end
            end
        end
    end

    // payload: request word, search results, entry store, result word
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load) begin
            r_cmd <= i_cmd;
            r_key <= i_lookup_key;
            r_val <= i_write_value;
        end
        if (i_cmd_bus.search) begin
            r_hit   <= any_match;
            r_evict <= (r_cmd == lkv_pkg::CMD_PUT) && !any_match && full;
            if (any_match) begin
                r_sel <= match_idx;
            end else if (full) begin
                r_sel <= oldest_idx;
            end else begin
                r_sel <= free_idx;
            end
        end
        if (i_cmd_bus.commit) begin
            r_out_hit     <= r_hit;
            r_out_evicted <= r_evict;
            r_out_evk     <= r_evict ? r_keys[r_sel] : '0;
            if (r_cmd == lkv_pkg::CMD_GET) begin
                r_out_read <= r_hit ? r_values[r_sel] : lkv_pkg::MISS_VALUE;
            end else begin
                r_out_read <= '0;
                r_values[r_sel] <= r_val;
                if (!r_hit) begin
                    r_keys[r_sel] <= r_key;
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_read;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = r_out_evk;

endmodule

/* src/lru_key_value_cache.sv */
// Top level of the LRU key/value cache: controller plus datapath.
`timescale 1ns / 1ps

// A request word is taken when start is high and busy is low; each request
// passes through accept, parallel key search and commit of ranks and entry,
// set by the controller's search and commit steps. Busy stays high until the
// commit is done, so a new word is not taken before the last one is through.
// The result word is registered by the commit step and shows on the o_ ports
// for exactly one cycle, marked by o_valid; it cannot be stalled and must be
// captured in that cycle. Capacity may be written any time the block is idle;
// a value of 0 acts as 1 and values above the entry count act as the entry count.
module lru_key_value_cache (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  logic                              i_cmd,
    input  logic signed [lkv_pkg::WORD_W-1:0] i_lookup_key,
    input  logic signed [lkv_pkg::WORD_W-1:0] i_write_value,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic signed [lkv_pkg::WORD_W-1:0] o_read_value,
    output logic                              o_evicted,
    output logic signed [lkv_pkg::WORD_W-1:0] o_evicted_key
);

    lkv_pkg::t_ctrl_cmd cmd_bus;

    lkv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd_bus)
    );

    lkv_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_bus     (cmd_bus),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (i_cmd),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

endmodule

/* src/lkv_checker.sv */
// Port-level checker for the LRU key/value cache, bound to the top level.
`timescale 1ns / 1ps

module lkv_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic                              o_hit,
    input logic signed [lkv_pkg::WORD_W-1:0] o_read_value,
    input logic                              o_evicted,
    input logic signed [lkv_pkg::WORD_W-1:0] o_evicted_key
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted word");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##3 o_valid)
        else $error("result word missing after accepted word");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_evict_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> !o_hit && (o_read_value == '0))
        else $error("eviction on a hit or with nonzero read value");

    a_no_evict_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evicted |-> (o_evicted_key == '0))
        else $error("evicted key nonzero without eviction");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_hit         (o_hit),
    .o_read_value  (o_read_value),
    .o_evicted     (o_evicted),
    .o_evicted_key (o_evicted_key)
);

/* tb/lru_key_value_cache_test.sv */
// Self-checking testbench for the LRU key/value cache: random get/put traffic, LRU predictor.
`timescale 1ns / 1ps

module lru_key_value_cache_test;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic                       cmd;
        logic [lkv_pkg::WORD_W-1:0] lookup_key;
        logic [lkv_pkg::WORD_W-1:0] write_value;
    } t_request;

    typedef struct {
        logic                       hit;
        logic [lkv_pkg::WORD_W-1:0] read_value;
        logic                       evicted;
        logic [lkv_pkg::WORD_W-1:0] evicted_key;
    } t_outcome;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       i_cfg_we = 1'b0;
    logic [lkv_pkg::CAP_W-1:0]  i_cfg_wdata = '0;
    logic                       i_cmd = lkv_pkg::CMD_GET;
    logic [lkv_pkg::WORD_W-1:0] i_lookup_key = '0;
    logic [lkv_pkg::WORD_W-1:0] i_write_value = '0;
    logic                       o_valid;
    logic                       o_hit;
    logic [lkv_pkg::WORD_W-1:0] o_read_value;
    logic                       o_evicted;
    logic [lkv_pkg::WORD_W-1:0] o_evicted_key;

    t_request request_q[$];
    t_outcome outcome_q[$];
    int       mismatches = 0;
    int       gap_left = 0;
    int       quiet_cycles = 0;
    bit       steady = 1'b0;

    logic [lkv_pkg::WORD_W-1:0] slot_key[lkv_pkg::ENTRIES];
    logic [lkv_pkg::WORD_W-1:0] slot_val[lkv_pkg::ENTRIES];
    bit                         slot_used[lkv_pkg::ENTRIES];
    int                         slot_age[lkv_pkg::ENTRIES];
    int                         used_count = 0;
    logic [lkv_pkg::CAP_W-1:0]  capacity_reg = lkv_pkg::CAP_RESET;

    lru_key_value_cache uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (i_cmd),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    always #10 i_clk = ~i_clk;

    function automatic void make_newest(int s);
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (slot_used[i] && i != s && slot_age[i] < slot_age[s])
                slot_age[i]++;
        end
        slot_age[s] = 0;
    endfunction

    function automatic t_outcome cache_access(t_request r);
        t_outcome o;
        int       s;
        int       victim;
        int       limit;
        o = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
        s = -1;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (s < 0 && slot_used[i] && slot_key[i] == r.lookup_key)
                s = i;
        end
        o.hit = (s >= 0);
        if (r.cmd == lkv_pkg::CMD_GET) begin
            if (s >= 0) begin
                o.read_value = slot_val[s];
                make_newest(s);
            end else begin
                o.read_value = lkv_pkg::MISS_VALUE;
            end
        end else if (s >= 0) begin
            slot_val[s] = r.write_value;
            make_newest(s);
        end else begin
            if (capacity_reg == '0)
                limit = 1;
            else if (int'(capacity_reg) > lkv_pkg::ENTRIES)
                limit = lkv_pkg::ENTRIES;
            else
                limit = int'(capacity_reg);
            victim = -1;
            if (used_count >= limit) begin
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                        victim = i;
                end
                if (victim < 0)
                    victim = 0;
                o.evicted = 1'b1;
                o.evicted_key = slot_key[victim];
                slot_used[victim] = 1'b0;
                used_count--;
            end else begin
                for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
                    if (!slot_used[i])
                        victim = i;
                end
                if (victim < 0)
                    victim = 0;
            end
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                if (slot_used[i])
                    slot_age[i]++;
            end
            slot_key[victim] = r.lookup_key;
            slot_val[victim] = r.write_value;
            slot_used[victim] = 1'b1;
            slot_age[victim] = 0;
            used_count++;
        end
        return o;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (steady || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 96)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    always @(posedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                r = request_q.pop_front();
                outcome_q.push_back(cache_access(r));
                gap_left = pick_gap();
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (request_q.size() > 0) begin
                start <= 1'b1;
                i_cmd <= request_q[0].cmd;
                i_lookup_key <= request_q[0].lookup_key;
                i_write_value <= request_q[0].write_value;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result word: hit=%0d read_value=%h", o_hit, o_read_value);
                mismatches++;
            end else begin
                want = outcome_q.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    mismatches++;
                end
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, o_read_value);
                    mismatches++;
                end
                if (o_evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, o_evicted);
                    mismatches++;
                end
                if (o_evicted_key !== want.evicted_key) begin
                    $error("evicted_key: expected %h, got %h", want.evicted_key, o_evicted_key);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_req(logic cmd, logic [lkv_pkg::WORD_W-1:0] k,
                            logic [lkv_pkg::WORD_W-1:0] v);
        request_q.push_back('{cmd: cmd, lookup_key: k, write_value: v});
    endtask

    task automatic push_random(int count, int pool_n);
        logic [lkv_pkg::WORD_W-1:0] pool[$];
        logic [lkv_pkg::WORD_W-1:0] k;
        for (int i = 0; i < pool_n; i++)
            pool.push_back($urandom());
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 85)
                k = pool[$urandom_range(pool_n - 1)];
            else
                k = $urandom();
            push_req(1'($urandom_range(1)), k, $urandom());
        end
    endtask

    task automatic drain();
        while (request_q.size() != 0 || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        capacity_reg = v;
        @(posedge i_clk);
    endtask

    initial begin
        logic [lkv_pkg::CAP_W-1:0] cap;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_age[i] = 0;
            slot_key[i] = '0;
            slot_val[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_req(lkv_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        push_req(lkv_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        push_req(lkv_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        push_req(lkv_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        push_req(lkv_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(lkv_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000);
        push_req(lkv_pkg::CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_req(lkv_pkg::CMD_GET, 32'h0000_0000, 32'h1234_5678);
        push_req(lkv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        push_req(lkv_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0005);
        push_req(lkv_pkg::CMD_GET, 32'h0000_04D2, 32'h0000_0000);
        for (int i = 0; i < 14; i++)
            push_req(lkv_pkg::CMD_PUT, 32'd100 + i, $urandom());

        write_capacity(5'd3);
        push_req(lkv_pkg::CMD_PUT, 32'h5555_AAAA, 32'hAAAA_5555);
        push_req(lkv_pkg::CMD_GET, 32'h0000_0070, 32'h0000_0000);
        push_req(lkv_pkg::CMD_PUT, 32'h5555_AAAA, 32'h0F0F_F0F0);
        push_random(100, 6);

        write_capacity(5'd0);
        push_random(80, 3);
        write_capacity(5'd1);
        push_random(80, 3);
        write_capacity(5'd31);
        steady = 1'b1;
        push_random(130, 22);
        drain();
        steady = 1'b0;
        write_capacity(5'd17);
        push_random(100, 20);
        write_capacity(5'd2);
        push_random(80, 4);
        write_capacity(lkv_pkg::CAP_RESET);
        push_random(130, 20);
        cap = lkv_pkg::CAP_W'($urandom_range(lkv_pkg::ENTRIES, 1));
        write_capacity(cap);
        push_random(100, int'(cap) + 4);
        cap = lkv_pkg::CAP_W'($urandom_range(12, 4));
        write_capacity(cap);
        push_random(120, int'(cap) + 3);
        drain();

        if (mismatches == 0 && outcome_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
src/lkv_pkg.sv
src/lkv_ctrl.sv
src/lkv_dp.sv
src/lru_key_value_cache.sv
src/lkv_checker.sv
tb/lru_key_value_cache_test.sv
